### hdl/line_sensor_centroid_assert.svh
// Assertion macros used by the checker file of the line sensor centroid.
// Depends on nothing; include by bare file name.
`ifndef LINE_SENSOR_CENTROID_ASSERT_SVH
`define LINE_SENSOR_CENTROID_ASSERT_SVH

// Same-cycle implication, held off while reset is asserted.
`define LSC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("line_sensor_centroid: same-cycle check failed");

// Next-cycle implication, held off while reset is asserted.
`define LSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("line_sensor_centroid: next-cycle check failed");

`endif

### hdl/lsc_pkg.sv
// Shared constants, command codes, status types and width helpers
// for the line sensor centroid. Depends on nothing.
package lsc_pkg;

	localparam int NUM_SENSORS_DEF = 8;
	localparam int SAMPLE_BITS_DEF = 12;
	localparam int SAMPLE_FIELDS   = 8;
	localparam int SAMPLE_W        = 12;
	localparam int CMD_W           = 2;
	localparam int POS_W           = 11;
	localparam int COUNT_W         = 4;
	localparam int FRAC_SHIFT      = 7;
	localparam int WHITE_DEFAULT   = 3850;
	localparam int BLACK_DEFAULT   = 4000;

	typedef enum logic [CMD_W-1:0] {
		CMD_MEASURE   = 2'd0,
		CMD_CAL_WHITE = 2'd1,
		CMD_CAL_BLACK = 2'd2
	} cmd_t;

	typedef struct packed {
		logic done;
		logic measure;
	} scan_stat_t;

	function automatic int idx_bits(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

	function automatic int cnt_bits(input int n);
		return $clog2(n + 1);
	endfunction

	// signed sum of weights, magnitude at most n*n/4
	function automatic int sum_bits(input int n);
		return $clog2(((n * n) >> 2) + 1) + 2;
	endfunction

endpackage

### hdl/lsc_if.sv
// Frame and result channel interfaces of the line sensor centroid.
// Depends on lsc_pkg.
interface lsc_frame_if;
	import lsc_pkg::*;
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    command;
	logic [SAMPLE_W-1:0] sample_0;
	logic [SAMPLE_W-1:0] sample_1;
	logic [SAMPLE_W-1:0] sample_2;
	logic [SAMPLE_W-1:0] sample_3;
	logic [SAMPLE_W-1:0] sample_4;
	logic [SAMPLE_W-1:0] sample_5;
	logic [SAMPLE_W-1:0] sample_6;
	logic [SAMPLE_W-1:0] sample_7;

	modport source (output valid, command, sample_0, sample_1, sample_2, sample_3,
		sample_4, sample_5, sample_6, sample_7, input ready);
	modport sink (input valid, command, sample_0, sample_1, sample_2, sample_3,
		sample_4, sample_5, sample_6, sample_7, output ready);
endinterface

interface lsc_result_if;
	import lsc_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] line_position;
	logic [COUNT_W-1:0]      active_count;

	modport source (output valid, line_position, active_count, input ready);
	modport sink (input valid, line_position, active_count, output ready);
endinterface

### hdl/lsc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module lsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hdl/lsc_scan.sv
// Per-sensor sweep over the reference RAM: calibration read-modify-write
// and threshold compare with weight accumulation. Depends on lsc_pkg, lsc_ram.
module lsc_scan #(
	parameter int NUM_SENSORS = lsc_pkg::NUM_SENSORS_DEF,
	parameter int SAMPLE_BITS = lsc_pkg::SAMPLE_BITS_DEF,
	localparam int IDX_W = lsc_pkg::idx_bits(NUM_SENSORS),
	localparam int SUM_W = lsc_pkg::sum_bits(NUM_SENSORS),
	localparam int CNT_W = lsc_pkg::cnt_bits(NUM_SENSORS)
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  lsc_pkg::cmd_t                          cmd,
	input  logic [NUM_SENSORS-1:0][SAMPLE_BITS-1:0] samples,
	output lsc_pkg::scan_stat_t                    stat,
	output logic signed [SUM_W-1:0]                sum,
	output logic [CNT_W-1:0]                       count
);
	import lsc_pkg::*;

	localparam logic [IDX_W-1:0]       LAST_IDX  = IDX_W'(NUM_SENSORS - 1);
	localparam logic [SAMPLE_BITS-1:0] WHITE_RST = SAMPLE_BITS'(WHITE_DEFAULT);
	localparam logic [SAMPLE_BITS-1:0] BLACK_RST = SAMPLE_BITS'(BLACK_DEFAULT);

	logic                     busy_q;
	logic [IDX_W-1:0]         idx_q;
	cmd_t                     cmd_q;
	logic                     rd_v_s1;
	logic [IDX_W-1:0]         rd_idx_s1;
	logic [NUM_SENSORS-1:0]   valid_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]         count_q;
	logic                     done_q;

	logic [2*SAMPLE_BITS-1:0] rdata;
	logic [2*SAMPLE_BITS-1:0] wdata;
	logic                     we;
	logic [SAMPLE_BITS-1:0]   ent_white;
	logic [SAMPLE_BITS-1:0]   ent_black;
	logic [SAMPLE_BITS-1:0]   samp;
	logic [SAMPLE_BITS:0]     thr_sum;
	logic                     active;
	logic signed [SUM_W-1:0]  weight;

	lsc_ram #(
		.WIDTH(2 * SAMPLE_BITS),
		.DEPTH(NUM_SENSORS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(rd_idx_s1),
		.wdata(wdata),
		.raddr(idx_q),
		.rdata(rdata)
	);

	always_comb begin
		ent_white = valid_q[rd_idx_s1] ? rdata[2*SAMPLE_BITS-1:SAMPLE_BITS] : WHITE_RST;
		ent_black = valid_q[rd_idx_s1] ? rdata[SAMPLE_BITS-1:0] : BLACK_RST;
		samp      = samples[rd_idx_s1];
		thr_sum   = {1'b0, ent_white} + {1'b0, ent_black};
		active    = samp < thr_sum[SAMPLE_BITS:1];
		weight    = SUM_W'(2 * int'(rd_idx_s1) - (NUM_SENSORS - 1));
		we        = rd_v_s1 && (cmd_q != CMD_MEASURE);
		wdata     = (cmd_q == CMD_CAL_WHITE) ? {samp, ent_black} : {ent_white, samp};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			idx_q     <= '0;
			cmd_q     <= CMD_MEASURE;
			rd_v_s1   <= 1'b0;
			rd_idx_s1 <= '0;
			valid_q   <= '0;
			sum_q     <= '0;
			count_q   <= '0;
			done_q    <= 1'b0;
		end else begin
			rd_v_s1   <= busy_q;
			rd_idx_s1 <= idx_q;
			done_q    <= rd_v_s1 && (rd_idx_s1 == LAST_IDX);
			if (start) begin
				busy_q  <= 1'b1;
				idx_q   <= '0;
				cmd_q   <= cmd;
				sum_q   <= '0;
				count_q <= '0;
			end else begin
				if (busy_q) begin
					if (idx_q == LAST_IDX) begin
						busy_q <= 1'b0;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				if (rd_v_s1 && (cmd_q == CMD_MEASURE) && active) begin
					sum_q   <= sum_q + weight;
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (we) begin
				valid_q[rd_idx_s1] <= 1'b1;
			end
		end
	end

	assign stat.done    = done_q;
	assign stat.measure = (cmd_q == CMD_MEASURE);
	assign sum          = sum_q;
	assign count        = count_q;

endmodule

### hdl/lsc_div.sv
// Bit-serial restoring divider: scaled weight sum over active count,
// truncating toward zero. Depends on lsc_pkg.
module lsc_div #(
	parameter int NUM_SENSORS = lsc_pkg::NUM_SENSORS_DEF,
	localparam int SUM_W  = lsc_pkg::sum_bits(NUM_SENSORS),
	localparam int CNT_W  = lsc_pkg::cnt_bits(NUM_SENSORS),
	localparam int MAG_W  = SUM_W + lsc_pkg::FRAC_SHIFT,
	localparam int STEP_W = $clog2(MAG_W + 1),
	localparam int EXT_W  = (MAG_W + 1 > lsc_pkg::POS_W) ? MAG_W + 1 : lsc_pkg::POS_W
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [SUM_W-1:0]          sum,
	input  logic [CNT_W-1:0]                 count,
	output logic                             done,
	output logic signed [lsc_pkg::POS_W-1:0] quot
);
	import lsc_pkg::*;

	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MAG_W - 1);

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [MAG_W-1:0]  qr_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  den_q;
	logic              neg_q;
	logic              zero_q;
	logic              done_q;

	logic [SUM_W-1:0]  mag;
	logic [CNT_W:0]    rem_sh;
	logic [CNT_W:0]    diff;
	logic              qbit;
	logic [EXT_W-1:0]  ext;
	logic [EXT_W-1:0]  res;

	always_comb begin
		mag    = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
		rem_sh = {rem_q, qr_q[MAG_W-1]};
		diff   = rem_sh - {1'b0, den_q};
		qbit   = rem_sh >= {1'b0, den_q};
		ext    = zero_q ? '0 : EXT_W'(qr_q);
		res    = neg_q ? -ext : ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			qr_q   <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			neg_q  <= 1'b0;
			zero_q <= 1'b1;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (step_q == LAST_STEP);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				qr_q   <= MAG_W'(mag) << FRAC_SHIFT;
				rem_q  <= '0;
				den_q  <= count;
				neg_q  <= sum[SUM_W-1];
				zero_q <= (count == '0);
			end else if (busy_q) begin
				qr_q  <= {qr_q[MAG_W-2:0], qbit};
				rem_q <= qbit ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
				end else begin
					step_q <= step_q + STEP_W'(1);
				end
			end
		end
	end

	assign done = done_q;
	assign quot = $signed(res[POS_W-1:0]);

endmodule

### hdl/line_sensor_centroid.sv
// Line sensor centroid: per-sensor white and black references live in one RAM
// (initial values 3850 and 4000, threshold their truncated mean); a calibrate
// frame rewrites one set, a measure frame yields one result holding the mean
// weight of sensors below threshold in 1/256 pitch and their count. Frames
// are taken one at a time; a calibrate frame is a sweep with one RAM access
// per sensor, and a measure frame adds one divider step per quotient bit
// (SUM_W + 7 steps) and a load of the result, which waits while the output
// register still holds a result that is not yet taken. A result waits in an
// output register while the next frame is already taken.
module line_sensor_centroid #(
	parameter int NUM_SENSORS = lsc_pkg::NUM_SENSORS_DEF,
	parameter int SAMPLE_BITS = lsc_pkg::SAMPLE_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	lsc_frame_if.sink   frame,
	lsc_result_if.source result
);
	import lsc_pkg::*;

	localparam int SUM_W = sum_bits(NUM_SENSORS);
	localparam int CNT_W = cnt_bits(NUM_SENSORS);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_PUSH = 4'b1000
	} state_t;

	state_t                                 state_q;
	state_t                                 state_d;
	logic [NUM_SENSORS-1:0][SAMPLE_BITS-1:0] samp_q;
	logic [NUM_SENSORS-1:0][SAMPLE_BITS-1:0] samp_d;
	logic [SAMPLE_W-1:0]                    fld [SAMPLE_FIELDS];
	logic                                   res_valid_q;
	logic signed [POS_W-1:0]                pos_q;
	logic [COUNT_W-1:0]                     cnt_q;

	logic                    accept;
	cmd_t                    cmd;
	logic                    scan_start;
	logic                    div_start;
	logic                    load;
	scan_stat_t              scan_stat;
	logic signed [SUM_W-1:0] sum;
	logic [CNT_W-1:0]        count;
	logic                    div_done;
	logic signed [POS_W-1:0] quot;

	assign fld[0] = frame.sample_0;
	assign fld[1] = frame.sample_1;
	assign fld[2] = frame.sample_2;
	assign fld[3] = frame.sample_3;
	assign fld[4] = frame.sample_4;
	assign fld[5] = frame.sample_5;
	assign fld[6] = frame.sample_6;
	assign fld[7] = frame.sample_7;

	for (genvar i = 0; i < NUM_SENSORS; i++) begin : g_samp
		if (i < SAMPLE_FIELDS) begin : g_field
			assign samp_d[i] = SAMPLE_BITS'(fld[i]);
		end else begin : g_full
			assign samp_d[i] = '1;
		end
	end

	assign frame.ready = (state_q == ST_IDLE);
	assign accept      = frame.valid && frame.ready;
	assign cmd         = cmd_t'(frame.command);

	always_comb begin
		state_d    = state_q;
		scan_start = 1'b0;
		div_start  = 1'b0;
		load       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd) inside
						CMD_MEASURE, CMD_CAL_WHITE, CMD_CAL_BLACK: begin
							scan_start = 1'b1;
							state_d    = ST_SCAN;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (scan_stat.done) begin
					div_start = scan_stat.measure;
					state_d   = scan_stat.measure ? ST_DIV : ST_IDLE;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				if (!res_valid_q || result.ready) begin
					load    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	lsc_scan #(
		.NUM_SENSORS(NUM_SENSORS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scan_start),
		.cmd    (cmd),
		.samples(samp_q),
		.stat   (scan_stat),
		.sum    (sum),
		.count  (count)
	);

	lsc_div #(
		.NUM_SENSORS(NUM_SENSORS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.sum   (sum),
		.count (count),
		.done  (div_done),
		.quot  (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_start) begin
			samp_q <= samp_d;
		end
		if (load) begin
			pos_q <= quot;
			cnt_q <= COUNT_W'(count);
		end
	end

	assign result.valid         = res_valid_q;
	assign result.line_position = pos_q;
	assign result.active_count  = cnt_q;

endmodule

### hdl/lsc_chk.sv
// Port-level checks of the line sensor centroid and their bind to the top.
// Depends on lsc_pkg, lsc_if and line_sensor_centroid_assert.svh.
`include "line_sensor_centroid_assert.svh"

module lsc_chk (
	input logic          clk,
	input logic          arst_n,
	lsc_frame_if.sink    frame,
	lsc_result_if.source result
);
	import lsc_pkg::*;

	`LSC_ASSERT_NEXT(a_res_hold, clk, arst_n, result.valid && !result.ready, result.valid)
	`LSC_ASSERT_NEXT(a_res_stable, clk, arst_n, result.valid && !result.ready, $stable(result.line_position) && $stable(result.active_count))
	`LSC_ASSERT_IMPLY(a_zero_count, clk, arst_n, result.valid && (result.active_count == '0), result.line_position == '0)
	`LSC_ASSERT_NEXT(a_busy_after_cmd, clk, arst_n, frame.valid && frame.ready && (frame.command == CMD_MEASURE || frame.command == CMD_CAL_WHITE || frame.command == CMD_CAL_BLACK), !frame.ready)

endmodule

bind line_sensor_centroid lsc_chk u_chk (
	.clk   (clk),
	.arst_n(arst_n),
	.frame (frame),
	.result(result)
);
